/* src/dbrt_pkg.sv */
// Shared types and constants for the dirty band region tracker.
// No dependencies; the band store and the top level import this package.
package dbrt_pkg;

	localparam int BAND_ROWS_DEF = 8;
	localparam int MAX_BANDS_DEF = 64;
	localparam int RESULT_CAP    = 64;

	localparam int MODE_W     = 2;
	localparam int COORD_W    = 12;
	localparam int SW_W       = 11;
	localparam int SH_W       = 10;
	localparam int RX_W       = 10;
	localparam int RY_W       = 9;
	localparam int RW_W       = 11;
	localparam int RH_W       = 10;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;

	localparam logic [SW_W-1:0] SCREEN_WIDTH_RST  = SW_W'(640);
	localparam logic [SH_W-1:0] SCREEN_HEIGHT_RST = SH_W'(480);
	localparam logic [SW_W-1:0] SCREEN_WIDTH_MAX  = SW_W'(1024);

	localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FLUSH = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

	typedef struct packed {
		logic            dirty;
		logic [RX_W-1:0] left;
		logic [RW_W-1:0] width;
	} band_t;

endpackage

/* src/dbrt_band_mem.sv */
// Band store: one word (dirty, left, width) per band, single write port,
// one registered read port. Depends on dbrt_pkg for band_t.
module dbrt_band_mem #(
	parameter int DEPTH  = dbrt_pkg::MAX_BANDS_DEF,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                clk,
	input  logic                we,
	input  logic [ADDR_W-1:0]   waddr,
	input  dbrt_pkg::band_t     wdata,
	input  logic                re,
	input  logic [ADDR_W-1:0]   raddr,
	output dbrt_pkg::band_t     rdata
);
	import dbrt_pkg::*;

	band_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* src/dirty_band_region_tracker.sv */
// Dirty band region tracker: one span per band, walked one band per cycle except while
// a flush waits on out_stall. Add: clamp the rectangle, then walk the bands from the top
// to the last touched band. Flush: walk every band, then ST_FL_END and ST_FL_FIN; out_stall
// can hold it, and it stops early at the result cap. Clear: zero every band. A new beat is
// taken only in ST_IDLE. After reset a clearing pass over every band runs before the first beat is taken.
// Depends on dbrt_pkg and dbrt_band_mem.
module dirty_band_region_tracker #(
	parameter int BAND_ROWS = dbrt_pkg::BAND_ROWS_DEF,
	parameter int MAX_BANDS = dbrt_pkg::MAX_BANDS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [dbrt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dbrt_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [dbrt_pkg::MODE_W-1:0]         mode,
	input  logic signed [dbrt_pkg::COORD_W-1:0] left,
	input  logic signed [dbrt_pkg::COORD_W-1:0] top,
	input  logic signed [dbrt_pkg::COORD_W-1:0] right,
	input  logic signed [dbrt_pkg::COORD_W-1:0] bottom,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [dbrt_pkg::RX_W-1:0]           rect_x,
	output logic [dbrt_pkg::RY_W-1:0]           rect_y,
	output logic [dbrt_pkg::RW_W-1:0]           rect_w,
	output logic [dbrt_pkg::RH_W-1:0]           rect_h,
	output logic                                last,
	output logic                                empty_res
);
	import dbrt_pkg::*;

	localparam int ADDR_W = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
	localparam int LINE_W = $clog2(MAX_BANDS * BAND_ROWS + 1);
	localparam int CMP_W  = (LINE_W > SH_W + 1) ? LINE_W : SH_W + 1;
	localparam int CNT_W  = $clog2(RESULT_CAP + 1);
	localparam logic [ADDR_W-1:0] LAST_B = ADDR_W'(MAX_BANDS - 1);
	localparam logic [LINE_W-1:0] ROWS   = LINE_W'(BAND_ROWS);
	localparam logic [CNT_W-1:0]  CAP_M1 = CNT_W'(RESULT_CAP - 1);

	typedef enum logic [2:0] {
		ST_CLR, ST_IDLE, ST_ADD_PREP, ST_ADD_EVAL, ST_FL_EVAL, ST_FL_END, ST_FL_FIN
	} state_t;

	state_t state_q;
	logic [SW_W-1:0]   sw_q;
	logic [SH_W-1:0]   sh_q;
	logic [COORD_W-1:0] left_q, top_q, right_q, bottom_q;
	logic [RX_W-1:0]   x1_q;
	logic [SW_W-1:0]   x2_q;
	logic [SH_W-1:0]   y1_q, y2_q;
	logic [ADDR_W-1:0] b_q;
	logic [LINE_W-1:0] base_q;
	logic [CNT_W-1:0]  n_q;
	logic              run_act_q;
	logic [RX_W-1:0]   rl_q;
	logic [RW_W-1:0]   rw_q;
	logic [LINE_W-1:0] run_y_q, run_h_q;
	logic              hold_valid_q;
	logic [RX_W-1:0]   hold_x_q;
	logic [RY_W-1:0]   hold_y_q;
	logic [RW_W-1:0]   hold_w_q;
	logic [RH_W-1:0]   hold_h_q;
	logic              out_valid_q;
	logic [RX_W-1:0]   rect_x_q;
	logic [RY_W-1:0]   rect_y_q;
	logic [RW_W-1:0]   rect_w_q;
	logic [RH_W-1:0]   rect_h_q;
	logic              last_q, empty_q;

	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	band_t             mem_wdata, rd;

	logic              accept, out_free;
	logic [SW_W-1:0]   wlim, x1c, x2c;
	logic [SW_W-1:0]   y1c, y2w;
	logic [SH_W-1:0]   y2c;
	logic              add_ok;
	logic [LINE_W-1:0] base_nxt;
	logic [ADDR_W-1:0] b_nxt;
	logic              add_touch, add_done;
	logic [RX_W-1:0]   l0, nl;
	logic [RW_W-1:0]   w0, nw;
	logic [RW_W:0]     span_end;
	logic              same, fl_block, fl_stop, fl_take;
	logic              out_load;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign base_nxt = base_q + ROWS;
	assign b_nxt    = b_q + ADDR_W'(1);

	// Clamp the rectangle held from the accepted beat
	always_comb begin
		wlim = (sw_q > SCREEN_WIDTH_MAX) ? SCREEN_WIDTH_MAX : sw_q;
		x1c  = left_q[COORD_W-1] ? '0 : left_q[SW_W-1:0];
		x2c  = (right_q[COORD_W-1] || right_q[SW_W-1:0] > wlim) ? wlim : right_q[SW_W-1:0];
		y1c  = top_q[COORD_W-1] ? '0 : top_q[SW_W-1:0];
		y2c  = (bottom_q[COORD_W-1] || bottom_q[SW_W-1:0] > SW_W'(sh_q))
			? sh_q : bottom_q[SH_W-1:0];
		y2w  = SW_W'(y2c);
		add_ok = (x1c < x2c) && (y1c < y2w);
	end

	// Unite the new span with the stored one
	always_comb begin
		add_touch = (CMP_W'(base_q) < CMP_W'(y2_q)) && (CMP_W'(base_nxt) > CMP_W'(y1_q));
		add_done  = (b_q == LAST_B) || (CMP_W'(base_nxt) >= CMP_W'(y2_q));
		if (rd.left > x1_q) begin
			l0 = x1_q;
			w0 = rd.width + RW_W'(rd.left - x1_q);
		end else begin
			l0 = rd.left;
			w0 = rd.width;
		end
		span_end = (RW_W + 1)'(l0) + (RW_W + 1)'(w0);
		if (!rd.dirty) begin
			nl = x1_q;
			nw = x2_q - RW_W'(x1_q);
		end else begin
			nl = l0;
			nw = (span_end < (RW_W + 1)'(x2_q)) ? x2_q - RW_W'(l0) : w0;
		end
	end

	// Flush decisions for the band just read
	always_comb begin
		same     = run_act_q && rd.dirty && rd.left == rl_q && rd.width == rw_q;
		fl_block = run_act_q && !same && hold_valid_q && !out_free;
		fl_stop  = run_act_q && !same && n_q == CAP_M1;
		fl_take  = !fl_stop && rd.dirty && !same;
		// load the result register from the held region or the final beat
		out_load = (state_q == ST_FL_EVAL && !fl_block && run_act_q && !same && hold_valid_q)
			|| (state_q == ST_FL_END && run_act_q && hold_valid_q && out_free)
			|| (state_q == ST_FL_FIN && out_free);
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = b_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		unique case (state_q)
			ST_CLR: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				mem_re = accept && mode == MODE_FLUSH;
			end
			ST_ADD_PREP: begin
				mem_re = add_ok;
			end
			ST_ADD_EVAL: begin
				mem_we    = add_touch;
				mem_wdata = '{dirty: 1'b1, left: nl, width: nw};
				mem_re    = !add_done;
				mem_raddr = b_nxt;
			end
			ST_FL_EVAL: begin
				mem_we    = !fl_block && (same || fl_take);
				mem_re    = !fl_block && !fl_stop && b_q != LAST_B;
				mem_raddr = b_nxt;
			end
			default: begin
			end
		endcase
	end

	dbrt_band_mem #(
		.DEPTH  (MAX_BANDS),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			sw_q         <= SCREEN_WIDTH_RST;
			sh_q         <= SCREEN_HEIGHT_RST;
			left_q       <= '0;
			top_q        <= '0;
			right_q      <= '0;
			bottom_q     <= '0;
			x1_q         <= '0;
			x2_q         <= '0;
			y1_q         <= '0;
			y2_q         <= '0;
			b_q          <= '0;
			base_q       <= '0;
			n_q          <= '0;
			run_act_q    <= 1'b0;
			rl_q         <= '0;
			rw_q         <= '0;
			run_y_q      <= '0;
			run_h_q      <= '0;
			hold_valid_q <= 1'b0;
			hold_x_q     <= '0;
			hold_y_q     <= '0;
			hold_w_q     <= '0;
			hold_h_q     <= '0;
			out_valid_q  <= 1'b0;
			rect_x_q     <= '0;
			rect_y_q     <= '0;
			rect_w_q     <= '0;
			rect_h_q     <= '0;
			last_q       <= 1'b0;
			empty_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SCREEN_WIDTH:  sw_q <= cfg_data[SW_W-1:0];
					REG_SCREEN_HEIGHT: sh_q <= cfg_data[SH_W-1:0];
					default: begin
					end
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLR: begin
					if (b_q == LAST_B) begin
						b_q     <= '0;
						state_q <= ST_IDLE;
					end else begin
						b_q <= b_nxt;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						left_q       <= left;
						top_q        <= top;
						right_q      <= right;
						bottom_q     <= bottom;
						b_q          <= '0;
						base_q       <= '0;
						n_q          <= '0;
						run_act_q    <= 1'b0;
						hold_valid_q <= 1'b0;
						unique case (mode)
							MODE_ADD:   state_q <= ST_ADD_PREP;
							MODE_FLUSH: state_q <= ST_FL_EVAL;
							MODE_CLEAR: state_q <= ST_CLR;
							default:    state_q <= ST_IDLE;
						endcase
					end
				end
				ST_ADD_PREP: begin
					x1_q    <= x1c[RX_W-1:0];
					x2_q    <= x2c;
					y1_q    <= y1c[SH_W-1:0];
					y2_q    <= y2c;
					state_q <= add_ok ? ST_ADD_EVAL : ST_IDLE;
				end
				ST_ADD_EVAL: begin
					if (add_done) begin
						b_q     <= '0;
						state_q <= ST_IDLE;
					end else begin
						b_q    <= b_nxt;
						base_q <= base_nxt;
					end
				end
				ST_FL_EVAL: begin
					if (!fl_block) begin
						if (same) begin
							run_h_q <= run_h_q + ROWS;
						end else begin
							if (run_act_q) begin
								// Close the run: pass the held one on, hold this one
								if (hold_valid_q) begin
									rect_x_q    <= hold_x_q;
									rect_y_q    <= hold_y_q;
									rect_w_q    <= hold_w_q;
									rect_h_q    <= hold_h_q;
									last_q      <= 1'b0;
									empty_q     <= 1'b0;
								end
								hold_valid_q <= 1'b1;
								hold_x_q     <= rl_q;
								hold_y_q     <= RY_W'(run_y_q);
								hold_w_q     <= rw_q;
								hold_h_q     <= RH_W'(run_h_q);
								n_q          <= n_q + CNT_W'(1);
							end
							run_act_q <= fl_take;
							if (fl_take) begin
								rl_q    <= rd.left;
								rw_q    <= rd.width;
								run_y_q <= base_q;
								run_h_q <= ROWS;
							end
						end
						if (fl_stop) begin
							state_q   <= ST_FL_FIN;
						end else if (b_q == LAST_B) begin
							state_q <= ST_FL_END;
						end else begin
							b_q    <= b_nxt;
							base_q <= base_nxt;
						end
					end
				end
				ST_FL_END: begin
					if (!run_act_q) begin
						state_q <= ST_FL_FIN;
					end else if (!hold_valid_q || out_free) begin
						if (hold_valid_q) begin
							rect_x_q    <= hold_x_q;
							rect_y_q    <= hold_y_q;
							rect_w_q    <= hold_w_q;
							rect_h_q    <= hold_h_q;
							last_q      <= 1'b0;
							empty_q     <= 1'b0;
						end
						hold_valid_q <= 1'b1;
						hold_x_q     <= rl_q;
						hold_y_q     <= RY_W'(run_y_q);
						hold_w_q     <= rw_q;
						hold_h_q     <= RH_W'(run_h_q);
						run_act_q    <= 1'b0;
						state_q      <= ST_FL_FIN;
					end
				end
				ST_FL_FIN: begin
					if (out_free) begin
						last_q      <= 1'b1;
						if (hold_valid_q) begin
							rect_x_q <= hold_x_q;
							rect_y_q <= hold_y_q;
							rect_w_q <= hold_w_q;
							rect_h_q <= hold_h_q;
							empty_q  <= 1'b0;
						end else begin
							rect_x_q <= '0;
							rect_y_q <= '0;
							rect_w_q <= '0;
							rect_h_q <= '0;
							empty_q  <= 1'b1;
						end
						hold_valid_q <= 1'b0;
						b_q          <= '0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign rect_x    = rect_x_q;
	assign rect_y    = rect_y_q;
	assign rect_w    = rect_w_q;
	assign rect_h    = rect_h_q;
	assign last      = last_q;
	assign empty_res = empty_q;

endmodule

/* dv/dirty_band_region_tracker_tb.sv */
// Self-checking bench for the dirty band region tracker: a band-level predictor
// follows every accepted beat, and each emitted region is checked in order.
// Depends on dbrt_pkg and the dirty_band_region_tracker RTL.
module dirty_band_region_tracker_tb;
	import dbrt_pkg::*;

	localparam int BANDS       = MAX_BANDS_DEF;
	localparam int ROWS        = BAND_ROWS_DEF;
	localparam int SETTLE      = 100;
	localparam int QUIET_LIMIT = 4000;
	localparam int PHASE_BEATS = 28;
	localparam int PHASES      = 8;

	// mode 3 has no meaning; the block must swallow it
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

	typedef struct packed {
		logic [MODE_W-1:0]         mode;
		logic signed [COORD_W-1:0] l;
		logic signed [COORD_W-1:0] t;
		logic signed [COORD_W-1:0] r;
		logic signed [COORD_W-1:0] b;
	} beat_t;

	typedef struct packed {
		logic [RX_W-1:0] x;
		logic [RY_W-1:0] y;
		logic [RW_W-1:0] w;
		logic [RH_W-1:0] h;
		logic            last;
		logic            empty;
	} rect_t;

	typedef struct packed {
		beat_t stim;
		logic  typed;
		rect_t want;
	} row_t;

	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]         cfg_index = REG_SCREEN_WIDTH;
	logic [CFG_DATA_W-1:0]        cfg_data  = '0;
	logic                         in_valid  = 1'b0;
	logic                         in_stall;
	logic [MODE_W-1:0]            mode      = MODE_ADD;
	logic signed [COORD_W-1:0]    left      = '0;
	logic signed [COORD_W-1:0]    top       = '0;
	logic signed [COORD_W-1:0]    right     = '0;
	logic signed [COORD_W-1:0]    bottom    = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [RX_W-1:0]              rect_x;
	logic [RY_W-1:0]              rect_y;
	logic [RW_W-1:0]              rect_w;
	logic [RH_W-1:0]              rect_h;
	logic                         last;
	logic                         empty_res;

	// predictor copy of the band store and the registers
	logic  band_set  [BANDS];
	int    band_x    [BANDS];
	int    band_span [BANDS];
	int    cfg_width;
	int    cfg_height;
	rect_t pending_rects [$];

	int    errors  = 0;
	int    quiet   = 0;
	int    rx_wait = 0;
	bit    calm    = 1'b0;
	rect_t want;
	row_t  plan [25];

	dirty_band_region_tracker DUT (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void wipe_bands();
		for (int i = 0; i < BANDS; i++) begin
			band_set[i]  = 1'b0;
			band_x[i]    = 0;
			band_span[i] = 0;
		end
	endfunction

	function automatic void mark_rect(beat_t bt);
		int x1, y1, sx2, sy2, x2, y2, lim_w, lim_h, used, b_end;
		x1    = $signed(bt.l);
		y1    = $signed(bt.t);
		sx2   = $signed(bt.r);
		sy2   = $signed(bt.b);
		lim_w = (cfg_width > 1024) ? 1024 : cfg_width;
		lim_h = cfg_height;
		if (x1 < 0) x1 = 0;
		if (y1 < 0) y1 = 0;
		// negative far edges count as huge and clamp to the limit
		x2 = (sx2 < 0 || sx2 > lim_w) ? lim_w : sx2;
		y2 = (sy2 < 0 || sy2 > lim_h) ? lim_h : sy2;
		if (x1 >= x2 || y1 >= y2) return;
		used = (lim_h + ROWS - 1) / ROWS;
		if (used > BANDS) used = BANDS;
		b_end = (y2 + ROWS - 1) / ROWS;
		if (b_end > used) b_end = used;
		for (int b = y1 / ROWS; b < b_end; b++) begin
			if (!band_set[b]) begin
				band_set[b]  = 1'b1;
				band_x[b]    = x1;
				band_span[b] = x2 - x1;
			end else begin
				if (band_x[b] > x1) begin
					band_span[b] += band_x[b] - x1;
					band_x[b]     = x1;
				end
				if (band_x[b] + band_span[b] < x2) band_span[b] = x2 - band_x[b];
			end
		end
	endfunction

	function automatic void flush_regions();
		int    i, start, rl, rw, n;
		rect_t held;
		i    = 0;
		n    = 0;
		held = '0;
		while (i < BANDS && n < RESULT_CAP) begin
			if (!band_set[i]) begin
				i++;
				continue;
			end
			start = i;
			rl    = band_x[i];
			rw    = band_span[i];
			do begin
				band_set[i]  = 1'b0;
				band_x[i]    = 0;
				band_span[i] = 0;
				i++;
			end while (i < BANDS && band_set[i] && band_x[i] == rl && band_span[i] == rw);
			// hold each region back one step so the final one can carry last
			if (n > 0) pending_rects.push_back(held);
			held   = '0;
			held.x = RX_W'(rl);
			held.y = RY_W'(start * ROWS);
			held.w = RW_W'(rw);
			held.h = RH_W'((i - start) * ROWS);
			n++;
		end
		if (n == 0) held.empty = 1'b1;
		held.last = 1'b1;
		pending_rects.push_back(held);
	endfunction

	function automatic void predict_beat(beat_t bt);
		case (bt.mode)
			MODE_ADD:   mark_rect(bt);
			MODE_FLUSH: flush_regions();
			MODE_CLEAR: wipe_bands();
			default: ;
		endcase
	endfunction

	function automatic row_t beat_row(logic [MODE_W-1:0] m, int l, int t, int r, int b);
		row_t row;
		row           = '0;
		row.stim.mode = m;
		row.stim.l    = COORD_W'(l);
		row.stim.t    = COORD_W'(t);
		row.stim.r    = COORD_W'(r);
		row.stim.b    = COORD_W'(b);
		return row;
	endfunction

	function automatic row_t flush_row(int x, int y, int w, int h, logic empty);
		row_t row;
		row            = '0;
		row.stim.mode  = MODE_FLUSH;
		row.typed      = 1'b1;
		row.want.x     = RX_W'(x);
		row.want.y     = RY_W'(y);
		row.want.w     = RW_W'(w);
		row.want.h     = RH_W'(h);
		row.want.last  = 1'b1;
		row.want.empty = empty;
		return row;
	endfunction

	function automatic beat_t roll_beat();
		beat_t bt;
		int    pick, lim_w, lim_h, x1, y1;
		lim_w = (cfg_width > 1024) ? 1024 : cfg_width;
		lim_h = cfg_height;
		bt.l  = COORD_W'($urandom);
		bt.t  = COORD_W'($urandom);
		bt.r  = COORD_W'($urandom);
		bt.b  = COORD_W'($urandom);
		pick  = $urandom_range(0, 99);
		if (pick < 60) begin
			bt.mode = MODE_ADD;
			case ($urandom_range(0, 3))
				0: ; // full-range noise, negative edges included
				1: begin
					x1   = $urandom_range(0, lim_w);
					y1   = $urandom_range(0, lim_h);
					bt.l = COORD_W'(x1);
					bt.t = COORD_W'(y1);
					bt.r = COORD_W'($urandom_range(x1, lim_w));
					bt.b = COORD_W'($urandom_range(y1, lim_h));
				end
				2: begin
					// band-aligned spans from a small set, so runs merge
					x1   = 16 * int'($urandom_range(0, 3));
					y1   = ROWS * int'($urandom_range(0, (lim_h + ROWS - 1) / ROWS));
					bt.l = COORD_W'(x1);
					bt.r = COORD_W'(x1 + 16 * int'($urandom_range(1, 2)));
					bt.t = COORD_W'(y1);
					bt.b = COORD_W'(y1 + ROWS * int'($urandom_range(1, 4)));
				end
				default: begin
					bt.l = COORD_W'(int'($urandom_range(0, 32)) - 16);
					bt.t = COORD_W'(int'($urandom_range(0, 32)) - 16);
					bt.r = COORD_W'(lim_w - 16 + int'($urandom_range(0, 32)));
					bt.b = COORD_W'(lim_h - 16 + int'($urandom_range(0, 32)));
				end
			endcase
		end else if (pick < 85) begin
			bt.mode = MODE_FLUSH;
		end else if (pick < 92) begin
			bt.mode = MODE_CLEAR;
		end else begin
			bt.mode = MODE_SPARE;
		end
		return bt;
	endfunction

	// called just after a falling edge; returns just after one
	task automatic send_beat(input beat_t bt, input logic typed, input rect_t fixed);
		int gap;
		int depth;
		gap = calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		mode     = bt.mode;
		left     = bt.l;
		top      = bt.t;
		right    = bt.r;
		bottom   = bt.b;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		depth = pending_rects.size();
		predict_beat(bt);
		if (typed) begin
			// the typed-in region replaces what the predictor worked out
			while (pending_rects.size() > depth) void'(pending_rects.pop_back());
			pending_rects.push_back(fixed);
		end
		@(negedge clk);
	endtask

	task automatic settle_results(input int extra);
		in_valid = 1'b0;
		while (pending_rects.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == REG_SCREEN_WIDTH) cfg_width = int'(data[SW_W-1:0]);
		else cfg_height = int'(data[SH_W-1:0]);
	endtask

	function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
		if (got_v !== exp_v) begin
			errors++;
			$display("%0t  %s: expected %0d, got %0d", $time, name, exp_v, got_v);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_rects.size() == 0) begin
				errors++;
				$display("%0t  region with none expected: x %0d y %0d w %0d h %0d last %0b empty %0b",
					$time, rect_x, rect_y, rect_w, rect_h, last, empty_res);
			end else begin
				want = pending_rects.pop_front();
				check_field("rect_x", want.x, rect_x);
				check_field("rect_y", want.y, rect_y);
				check_field("rect_w", want.w, rect_w);
				check_field("rect_h", want.h, rect_h);
				check_field("last", want.last, last);
				check_field("empty_res", want.empty, empty_res);
			end
			rx_wait = calm ? 0 : $urandom_range(0, 8);
		end
	end

	// hold the result side off for the drawn count of cycles with a region on offer
	always @(negedge clk) begin
		out_stall = (rx_wait > 0);
		if (rx_wait > 0 && out_valid) rx_wait--;
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("dirty_band_region_tracker: mismatch");
				$finish;
			end
		end
	end

	initial begin
		beat_t bt;
		int    sent;
		int    new_w;
		int    new_h;
		bit    held_off;
		cfg_width  = int'(SCREEN_WIDTH_RST);
		cfg_height = int'(SCREEN_HEIGHT_RST);
		held_off   = 1'b0;
		wipe_bands();
		plan = '{
			flush_row(0, 0, 0, 0, 1'b1),
			beat_row(MODE_ADD, -2048, -2048, 2047, 2047),
			flush_row(0, 0, 640, 480, 1'b0),
			beat_row(MODE_ADD, 10, 20, -1, -1),
			flush_row(10, 16, 630, 464, 1'b0),
			beat_row(MODE_ADD, 100, 0, 100, 50),
			beat_row(MODE_ADD, 0, 40, 50, 40),
			beat_row(MODE_SPARE, 5, 5, 50, 50),
			flush_row(0, 0, 0, 0, 1'b1),
			beat_row(MODE_ADD, 0, 0, 8, 8),
			beat_row(MODE_ADD, 4, 0, 16, 8),
			beat_row(MODE_ADD, 0, 8, 16, 16),
			beat_row(MODE_ADD, 32, 24, 48, 40),
			beat_row(MODE_ADD, 40, 40, 64, 41),
			beat_row(MODE_FLUSH, 0, 0, 0, 0),
			beat_row(MODE_ADD, 600, 470, 2047, 2047),
			beat_row(MODE_CLEAR, 0, 0, 0, 0),
			flush_row(0, 0, 0, 0, 1'b1),
			beat_row(MODE_ADD, -1, -1, 1, 1),
			beat_row(MODE_ADD, 639, 479, 640, 480),
			beat_row(MODE_ADD, -2048, 2047, 100, 2047),
			beat_row(MODE_FLUSH, 0, 0, 0, 0),
			beat_row(MODE_ADD, 0, 0, 640, 480),
			flush_row(0, 0, 640, 480, 1'b0),
			flush_row(0, 0, 0, 0, 1'b1)
		};
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) send_beat(plan[i].stim, plan[i].typed, plan[i].want);

		for (int p = 0; p < PHASES; p++) begin
			settle_results(SETTLE);
			case (p)
				0: begin new_w = 640;  new_h = 480;  end
				1: begin new_w = 1024; new_h = 512;  end
				2: begin new_w = 2047; new_h = 1023; end
				3: begin new_w = 1;    new_h = 1;    end
				4: begin new_w = 0;    new_h = 480;  end
				5: begin new_w = 640;  new_h = 0;    end
				6: begin
					new_w = $urandom_range(1, 1024);
					new_h = $urandom_range(1, 512);
				end
				default: begin
					// top data bit is dropped by the height register
					new_w = $urandom_range(0, 2047);
					new_h = $urandom_range(0, 2047);
				end
			endcase
			write_reg(REG_SCREEN_WIDTH, CFG_DATA_W'(new_w));
			write_reg(REG_SCREEN_HEIGHT, CFG_DATA_W'(new_h));
			calm = (p == 2);
			sent = 0;
			while (sent < PHASE_BEATS) begin
				bt = roll_beat();
				send_beat(bt, 1'b0, '0);
				if (bt.mode != MODE_SPARE) sent++;
				if (bt.mode == MODE_FLUSH && (!held_off || $urandom_range(0, 7) == 0)) begin
					held_off = 1'b1;
					settle_results(0);
				end
			end
		end

		settle_results(SETTLE);
		if (errors == 0) $display("dirty_band_region_tracker: match");
		else $display("dirty_band_region_tracker: mismatch");
		$finish;
	end

endmodule

/* dirty_band_region_tracker.f */
src/dbrt_pkg.sv
src/dbrt_band_mem.sv
src/dirty_band_region_tracker.sv
dv/dirty_band_region_tracker_tb.sv
